// ===== hw/rtl/windowed_peak_detector_unit_assert.svh =====
// Assertion macros shared by the checker of the peak detector.
`ifndef WINDOWED_PEAK_DETECTOR_UNIT_ASSERT_SVH
`define WINDOWED_PEAK_DETECTOR_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define WPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define WPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/wpd_pkg.sv =====
package wpd_pkg;

    localparam int MAX_WINDOW  = 32;
    localparam int MAX_LEN     = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int RING_DEPTH  = 2 * MAX_WINDOW + 1;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int K_W   = $clog2(2 * MAX_WINDOW + 1);

    localparam int WCFG_W   = 6;
    localparam int PROM_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CIDX_W   = 1;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    localparam logic [WCFG_W-1:0] W_RESET = WCFG_W'(25);

    localparam logic [CIDX_W-1:0] REG_WINDOW     = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] REG_PROMINENCE = CIDX_W'(1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CENTER = 5'b00010,
        ST_WALK   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(RING_DEPTH - 1)) r = '0;
        else r = p + PTR_W'(1);
        return r;
    endfunction

    // Ring pointer minus an offset below the ring depth, modulo the depth.
    function automatic logic [PTR_W-1:0] ptr_sub(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W-1:0] d);
        logic [PTR_W:0] t;
        if (p >= d) t = {1'b0, p} - {1'b0, d};
        else t = {1'b0, p} + (PTR_W+1)'(RING_DEPTH) - {1'b0, d};
        return t[PTR_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/windowed_peak_detector_unit.sv =====
// Channel   Dir  tdata (low bit up)                      tlast            tuser
// s_axis    in   sample[15:0]                            last             -
// m_axis    out  peak_index[11:0], peak_valid, 3'b0      end_of_sequence  -
// cfg       in   index 0: window_half_width, 1: prominence threshold
//
// While a center is evaluated, the window walk reads one ring entry per cycle through
// the single read port of the 65-entry sample ring.
// Reset clears the state, counters, config and handshake registers; the ring needs no clearing.
// A stalled result waits in the output register while the next request is taken.
module windowed_peak_detector_unit
    import wpd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // sample[15:0]
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // peak_index[11:0], peak_valid, zero pad
    output logic                m_tlast,
    input  logic                cfg_wen,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];

    state_t state_reg, state_next;

    logic [WCFG_W-1:0]      wcfg_reg;
    logic [PROM_W-1:0]      prom_cfg_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [IDX_W-1:0]       last_peak_reg;
    logic                   have_peak_reg;

    logic [WIN_W-1:0]       w_reg;
    logic [PROM_W-1:0]      minp_reg;
    logic [IDX_W-1:0]       center_reg;
    logic [PTR_W-1:0]       cen_addr_reg;
    logic [PTR_W-1:0]       addr_reg;
    logic [K_W-1:0]         k_reg;
    logic [K_W-1:0]         dk_reg;
    logic                   cen_vld_reg;
    logic                   win_vld_reg;
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic [SAMPLE_BITS-1:0] cur_reg;
    logic [SAMPLE_BITS-1:0] lmin_reg;
    logic [SAMPLE_BITS-1:0] rmin_reg;
    logic                   fail_reg;
    logic                   eval_reg;
    logic                   last_reg;

    logic                   m_tvalid_reg;
    logic [M_DATA_W-1:0]    m_tdata_reg;
    logic                   m_tlast_reg;

    logic                   accept;
    logic [WIN_W-1:0]       w_eff;
    logic                   stored;
    logic                   do_eval;
    logic                   rd_en;
    logic [PTR_W-1:0]       rd_addr;
    logic [K_W-1:0]         k_end;
    logic [SAMPLE_BITS-1:0] base;
    logic [SAMPLE_BITS-1:0] prom;
    logic [IDX_W:0]         gap;
    logic                   found;
    logic                   need_out;
    logic                   fin_go;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb
    begin
        if (wcfg_reg == '0) w_eff = WIN_W'(1);
        else if ({1'b0, wcfg_reg} > (WCFG_W+1)'(MAX_WINDOW)) w_eff = WIN_W'(MAX_WINDOW);
        else w_eff = WIN_W'(wcfg_reg);
    end

    assign stored  = (count_reg < CNT_W'(MAX_LEN));
    assign do_eval = stored && (count_reg >= CNT_W'({w_eff, 1'b0}));
    assign k_end   = K_W'({w_reg, 1'b0});

    assign rd_en   = (state_reg == ST_CENTER) || (state_reg == ST_WALK);
    assign rd_addr = (state_reg == ST_CENTER) ? cen_addr_reg : addr_reg;

    // Prominence test and spacing to the previous reported peak.
    assign base     = (lmin_reg > rmin_reg) ? lmin_reg : rmin_reg;
    assign prom     = cur_reg - base;
    assign gap      = {1'b0, center_reg} - {1'b0, last_peak_reg};
    assign found    = eval_reg && !fail_reg && (prom >= SAMPLE_BITS'(minp_reg))
                      && (!have_peak_reg || (gap > (IDX_W+1)'(w_reg >> 1)));
    assign need_out = found || last_reg;
    assign fin_go   = !(need_out && m_tvalid_reg && !m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept) state_next = do_eval ? ST_CENTER : ST_FINISH;
            end
            ST_CENTER: state_next = ST_WALK;
            ST_WALK:
            begin
                if (k_reg == k_end) state_next = ST_DRAIN;
            end
            ST_DRAIN:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (fin_go) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (accept && stored) ring_mem[wr_ptr_reg] <= s_tdata;
        if (rd_en) rd_data_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wcfg_reg      <= W_RESET;
            prom_cfg_reg  <= '0;
            count_reg     <= '0;
            wr_ptr_reg    <= '0;
            last_peak_reg <= '0;
            have_peak_reg <= 1'b0;
            cen_vld_reg   <= 1'b0;
            win_vld_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_WINDOW:     wcfg_reg <= cfg_wdata[WCFG_W-1:0];
                    REG_PROMINENCE: prom_cfg_reg <= cfg_wdata[PROM_W-1:0];
                    default:        ;
                endcase
            end

            if (accept)
            begin
                if (s_tlast)
                begin
                    count_reg  <= '0;
                    wr_ptr_reg <= '0;
                end
                else if (stored)
                begin
                    count_reg  <= count_reg + CNT_W'(1);
                    wr_ptr_reg <= ptr_inc(wr_ptr_reg);
                end
            end

            cen_vld_reg <= (state_reg == ST_CENTER);
            win_vld_reg <= (state_reg == ST_WALK);

            if ((state_reg == ST_FINISH) && fin_go)
            begin
                if (last_reg)
                begin
                    last_peak_reg <= '0;
                    have_peak_reg <= 1'b0;
                end
                else if (found)
                begin
                    last_peak_reg <= center_reg;
                    have_peak_reg <= 1'b1;
                end
            end

            if ((state_reg == ST_FINISH) && fin_go && need_out) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // Datapath registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            w_reg        <= w_eff;
            minp_reg     <= prom_cfg_reg;
            eval_reg     <= do_eval;
            last_reg     <= s_tlast;
            center_reg   <= IDX_W'(count_reg - CNT_W'(w_eff));
            cen_addr_reg <= ptr_sub(wr_ptr_reg, PTR_W'(w_eff));
            addr_reg     <= ptr_sub(wr_ptr_reg, PTR_W'({w_eff, 1'b0}));
            k_reg        <= '0;
            fail_reg     <= 1'b0;
            lmin_reg     <= '1;
            rmin_reg     <= '1;
        end

        if (state_reg == ST_WALK)
        begin
            addr_reg <= ptr_inc(addr_reg);
            k_reg    <= k_reg + K_W'(1);
            dk_reg   <= k_reg;
        end

        if (cen_vld_reg) cur_reg <= rd_data_reg;

        // Fold one window sample per cycle.
        if (win_vld_reg)
        begin
            if (rd_data_reg > cur_reg) fail_reg <= 1'b1;
            if ((dk_reg < K_W'(w_reg)) && (rd_data_reg < lmin_reg)) lmin_reg <= rd_data_reg;
            if ((dk_reg > K_W'(w_reg)) && (rd_data_reg < rmin_reg)) rmin_reg <= rd_data_reg;
        end

        if ((state_reg == ST_FINISH) && fin_go && need_out)
        begin
            m_tdata_reg <= M_DATA_W'({found, (found ? center_reg : IDX_W'(0))});
            m_tlast_reg <= last_reg;
        end
    end

endmodule

// ===== hw/rtl/wpd_checker.sv =====
`include "windowed_peak_detector_unit_assert.svh"

module wpd_checker
    import wpd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tlast
);

    `WPD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
    `WPD_ASSERT_NOW(a_out_cause, m_tvalid, m_tdata[12] || m_tlast, "result with neither peak nor end of sequence")
    `WPD_ASSERT_NOW(a_idx_zero, m_tvalid && !m_tdata[12], m_tdata[11:0] == 12'd0, "peak_index nonzero without peak")
    `WPD_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[15:13] == 3'd0, "tdata padding not zero")
    `WPD_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request taken while previous still in work")

endmodule

bind windowed_peak_detector_unit wpd_checker u_wpd_checker (.*);

// ===== tb/testbench.sv =====
module testbench
    import wpd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] sample;
        logic        last;
    } sample_req_t;

    typedef struct {
        logic [11:0] index;
        logic        valid;
        logic        eos;
    } peak_report_t;

    typedef enum int {SHAPE_NOISE, SHAPE_WALK, SHAPE_FLAT, SHAPE_SPIKES} shape_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                cfg_wen = 1'b0;
    logic [CIDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    // Predictor state and its copy of the registers
    logic [15:0]  hist_ring [0:RING_DEPTH-1];
    int unsigned  seq_count;
    int unsigned  last_peak;
    bit           peak_seen;
    logic [5:0]   win_reg;
    logic [15:0]  prom_reg;

    sample_req_t  send_q [$];
    peak_report_t peak_reports_q [$];
    sample_req_t  next_req;
    peak_report_t want;

    int  send_gap = 0;
    int  recv_gap = 0;
    int  recv_next;
    bit  no_gaps = 1'b0;
    int  hold_left = 0;
    int  hold_at = 0;
    bit  hold_done = 1'b0;

    int  error_cnt = 0;
    int  accepted_cnt = 0;
    int  results_seen = 0;
    int  peaks_seen = 0;
    int  seq_total = 0;
    int  phase_total = 0;

    windowed_peak_detector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_cnt++;
    endtask

    // Store one sample and evaluate the center that it completes, if any.
    task automatic predict_peak(input logic [15:0] smp, input logic lst);
        int unsigned  j, w, c, k;
        logic [16:0]  lmin, rmin;
        logic [15:0]  cur, v, base, prom_v;
        bit           tallest, found;
        peak_report_t rep;
        found = 1'b0;
        rep.index = '0;
        if (seq_count < MAX_LEN)
        begin
            j = seq_count;
            w = (win_reg == 0) ? 1 : ((win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg);
            hist_ring[j % RING_DEPTH] = smp;
            seq_count = j + 1;
            if (j >= 2 * w)
            begin
                c = j - w;
                cur = hist_ring[c % RING_DEPTH];
                lmin = '1;
                rmin = '1;
                tallest = 1'b1;
                for (k = c - w; k <= c + w; k++)
                begin
                    v = hist_ring[k % RING_DEPTH];
                    if (v > cur)
                        tallest = 1'b0;
                    if (k < c && v < lmin)
                        lmin = v;
                    if (k > c && v < rmin)
                        rmin = v;
                end
                base = (lmin > rmin) ? lmin[15:0] : rmin[15:0];
                prom_v = cur - base;
                // unsigned distance: a center behind the last peak passes
                if (tallest && prom_v >= prom_reg && (!peak_seen || c - last_peak > w / 2))
                begin
                    found = 1'b1;
                    rep.index = c[11:0];
                    last_peak = c;
                    peak_seen = 1'b1;
                end
            end
        end
        if (lst)
        begin
            seq_count = 0;
            last_peak = 0;
            peak_seen = 1'b0;
        end
        if (found || lst)
        begin
            rep.valid = found;
            rep.eos = lst;
            peak_reports_q.insert(peak_reports_q.size(), rep);
        end
    endtask

    // Sender: one request at a time, with a random gap after each
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_peak(s_tdata, s_tlast);
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (send_q.size() != 0)
                begin
                    next_req = send_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_req.sample;
                    s_tlast <= next_req.last;
                    send_gap <= no_gaps ? 0 : $urandom_range(0, 5);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: check each result, then stall a random number of cycles
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            recv_next = recv_gap;
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (peak_reports_q.size() == 0)
                    report_mismatch($sformatf("unexpected result data %h last %b",
                                              m_tdata, m_tlast));
                else
                begin
                    want = peak_reports_q.pop_front();
                    if (want.valid)
                        peaks_seen++;
                    if (m_tdata[11:0] !== want.index)
                        report_mismatch($sformatf("peak_index %0d, expected %0d",
                                                  m_tdata[11:0], want.index));
                    if (m_tdata[12] !== want.valid)
                        report_mismatch($sformatf("peak_valid %b, expected %b",
                                                  m_tdata[12], want.valid));
                    if (m_tlast !== want.eos)
                        report_mismatch($sformatf("end_of_sequence %b, expected %b",
                                                  m_tlast, want.eos));
                    if (m_tdata[15:13] !== 3'b000)
                        report_mismatch($sformatf("pad bits %b not zero", m_tdata[15:13]));
                end
                recv_next = no_gaps ? 0 : $urandom_range(0, 5);
            end
            else if (recv_next != 0)
                recv_next = recv_next - 1;
            recv_gap <= recv_next;
            m_tready <= (recv_next == 0) && (hold_left == 0);
        end
    end

    // Long receiver hold-off once, while the sender keeps offering
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && hold_at != 0 && accepted_cnt >= hold_at)
        begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wen <= 1'b0;
        if (idx == REG_WINDOW)
            win_reg = val[5:0];
        else
            prom_reg = val;
    endtask

    task automatic push_sample(input logic [15:0] smp, input logic lst);
        sample_req_t it;
        it.sample = smp;
        it.last = lst;
        send_q.insert(send_q.size(), it);
    endtask

    task automatic queue_sequence(input int len, input shape_t shp, input bit close);
        int i, lvl;
        lvl = $urandom_range(0, 65533);
        for (i = 0; i < len; i++)
        begin
            case (shp)
                SHAPE_NOISE:
                    push_sample(16'($urandom), close && i == len - 1);
                SHAPE_WALK:
                begin
                    lvl = lvl + int'($urandom_range(0, 4000)) - 2000;
                    if (lvl < 0)
                        lvl = 0;
                    if (lvl > 65535)
                        lvl = 65535;
                    push_sample(16'(lvl), close && i == len - 1);
                end
                SHAPE_FLAT:
                    push_sample(16'(lvl + $urandom_range(0, 2)), close && i == len - 1);
                default:
                    push_sample(($urandom_range(0, 9) == 0) ? 16'hFFFF :
                                16'($urandom_range(0, 3)), close && i == len - 1);
            endcase
        end
        seq_total++;
    endtask

    // Wait until every request is taken and every result is back, then let
    // the block finish any evaluation that causes no result.
    task automatic wait_idle(input int limit);
        int n;
        n = 0;
        while ((send_q.size() != 0 || s_tvalid || peak_reports_q.size() != 0) && n < limit)
        begin
            @(posedge clk);
            n++;
        end
        repeat (100) @(posedge clk);
    endtask

    initial
    begin
        #32_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int          p, nseq, s, len, w_eff, rand_items;
        logic [5:0]  w_set;
        logic [15:0] prom_set;
        bit          close;
        foreach (hist_ring[i])
            hist_ring[i] = '0;
        seq_count = 0;
        last_peak = 0;
        peak_seen = 1'b0;
        win_reg = W_RESET;
        prom_reg = '0;
        rand_items = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: single-sample run, peak on the closing sample, extremes, plateau
        write_reg(REG_WINDOW, 16'd2);
        write_reg(REG_PROMINENCE, 16'd0);
        push_sample(16'd7, 1'b1);
        push_sample(16'd0, 1'b0);
        push_sample(16'd0, 1'b0);
        push_sample(16'd9, 1'b0);
        push_sample(16'd0, 1'b0);
        push_sample(16'd0, 1'b1);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'd0, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'd0, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        repeat (5) push_sample(16'd5, 1'b0);
        push_sample(16'hFFFF, 1'b1);
        seq_total += 3;
        wait_idle(100000);

        p = 0;
        while (rand_items < 1900 || p < 6)
        begin
            case (p)
                0: begin w_set = 6'd0;  prom_set = 16'd0;    end
                1: begin w_set = 6'd63; prom_set = 16'hFFFF; end
                2: begin w_set = 6'd32; prom_set = 16'($urandom_range(0, 2000)); end
                3: begin w_set = 6'd1;  prom_set = 16'd200;  end
                4: begin w_set = 6'd25; prom_set = 16'd0;    end
                default:
                begin
                    w_set = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) :
                            6'($urandom_range(1, 6));
                    case ($urandom_range(0, 3))
                        0: prom_set = 16'd0;
                        1: prom_set = 16'($urandom_range(0, 1500));
                        2: prom_set = 16'($urandom_range(0, 6000));
                        default: prom_set = 16'($urandom_range(0, 65535));
                    endcase
                end
            endcase
            w_eff = (w_set == 0) ? 1 : ((w_set > MAX_WINDOW) ? MAX_WINDOW : w_set);
            write_reg(REG_WINDOW, CFG_W'(w_set));
            if (p < 6 || $urandom_range(0, 3) != 0)
                write_reg(REG_PROMINENCE, prom_set);
            no_gaps = (p % 4 == 2);

            if (p == 3)
            begin
                // Long run; hold the receiver off partway through it
                hold_at = accepted_cnt + 100;
                len = $urandom_range(300, 400);
                queue_sequence(len, SHAPE_WALK, 1'b1);
                rand_items += len;
            end
            else
            begin
                nseq = $urandom_range(2, 4);
                for (s = 0; s < nseq; s++)
                begin
                    // short runs reach a full window only when they extend a run left open
                    if ($urandom_range(0, 3) == 0)
                        len = $urandom_range(1, 2 * w_eff);
                    else
                        len = $urandom_range(2 * w_eff + 1, 2 * w_eff + 80);
                    // leave the final run open now and then so the next W applies mid-run
                    close = !(s == nseq - 1 && $urandom_range(0, 3) == 0);
                    queue_sequence(len, shape_t'($urandom_range(0, 3)), close);
                    rand_items += len;
                end
            end
            wait_idle(400000);
            p++;
        end
        phase_total = p;

        wait_idle(200000);
        if (peak_reports_q.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      peak_reports_q.size()));

        $display("Run covered %0d settings, %0d sequences, %0d samples accepted.",
                 phase_total, seq_total, accepted_cnt);
        $display("Checked %0d results, %0d of them peaks; %0d mismatches.",
                 results_seen, peaks_seen, error_cnt);
        if (error_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
